/* hw/rtl/sdr_pkg.sv */
// Shared types, widths and codes of the stereo disparity reprojection unit.
package sdr_pkg;

   localparam int COORD_BITS = 12;
   localparam int FIELD_BITS = 12;
   localparam int DISP_BITS  = COORD_BITS + 1;
   localparam int W_BITS     = 32 + DISP_BITS;
   localparam int AW_BITS    = W_BITS;
   localparam int D_BITS     = AW_BITS + 1;
   localparam int NUM_BITS   = 21;
   localparam int AN_BITS    = NUM_BITS;
   localparam int N_BITS     = ((AN_BITS + 29 > AW_BITS) ? AN_BITS + 29 : AW_BITS) + 1;
   localparam int Q_BITS     = 32;
   localparam int RAD_BITS   = 64;
   localparam int ROOT_BITS  = RAD_BITS / 2;
   localparam int SREM_BITS  = ROOT_BITS + 2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_WZERO = 2'd1;
   localparam logic [1:0] STATUS_SAT   = 2'd2;

   typedef enum logic [2:0] {
      CSR_PRINCIPAL_X   = 3'd0,
      CSR_PRINCIPAL_Y   = 3'd1,
      CSR_FOCAL_LENGTH  = 3'd2,
      CSR_DISPARITY_GAIN = 3'd3,
      CSR_W_OFFSET      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] left_col;
      logic [FIELD_BITS-1:0] left_row;
      logic [FIELD_BITS-1:0] right_col;
   } req_type;

   typedef struct packed {
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] world_z;
      logic [30:0]        range_dist;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        principal_x;
      logic [15:0]        principal_y;
      logic [19:0]        focal_length;
      logic signed [31:0] disparity_gain;
      logic signed [31:0] w_offset;
   } cfg_type;

   typedef struct packed {
      logic [D_BITS-1:0] rem;
      logic [Q_BITS-1:0] low;
      logic              neg;
      logic              ovf;
   } div_lane_type;

   typedef struct packed {
      logic                   wzero;
      logic [D_BITS-1:0]      dvs;
      div_lane_type [2:0]     lane;
   } div_stage_type;

   typedef struct packed {
      logic signed [31:0] wx;
      logic signed [31:0] wy;
      logic signed [31:0] wz;
      logic               sat;
      logic               wzero;
   } coord_type;

   typedef struct packed {
      coord_type             c;
      logic [SREM_BITS-1:0]  rem;
      logic [ROOT_BITS-1:0]  root;
      logic [RAD_BITS-1:0]   rad;
   } sq_stage_type;

endpackage

/* hw/rtl/sdr_front.sv */
// Front stages: disparity, homogeneous vector, magnitudes and divider setup.
module sdr_front import sdr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          ce,
   input  cfg_type       cfg,
   input  logic          in_valid,
   input  req_type       in_data,
   output logic          out_valid,
   output div_stage_type out_data
);

   typedef struct packed {
      logic [COORD_BITS-1:0] lx;
      logic [COORD_BITS-1:0] ly;
      logic [COORD_BITS-1:0] rx;
   } f1_type;

   typedef struct packed {
      logic signed [W_BITS-1:0]   w;
      logic signed [NUM_BITS-1:0] nx;
      logic signed [NUM_BITS-1:0] ny;
      logic signed [NUM_BITS-1:0] nz;
   } f2_type;

   typedef struct packed {
      logic [AW_BITS-1:0]         aw;
      logic                       wzero;
      logic [2:0][AN_BITS-1:0]    an;
      logic [2:0]                 neg;
   } f3_type;

   logic [3:0]    valid_ff;
   f1_type        f1_ff, f1_in;
   f2_type        f2_ff, f2_in;
   f3_type        f3_ff, f3_in;
   div_stage_type f4_ff, f4_in;

   logic signed [DISP_BITS-1:0] disp;
   logic signed [W_BITS-1:0]    prod;
   logic [N_BITS-1:0]           numer;
   logic signed [NUM_BITS-1:0]  nsel;

   always_comb begin
      f1_in.lx = COORD_BITS'(in_data.left_col);
      f1_in.ly = COORD_BITS'(in_data.left_row);
      f1_in.rx = COORD_BITS'(in_data.right_col);
   end

   always_comb begin
      disp = $signed({1'b0, f1_ff.lx}) - $signed({1'b0, f1_ff.rx});
      prod = cfg.disparity_gain * disp;
      f2_in.w  = prod + W_BITS'(cfg.w_offset);
      f2_in.nx = $signed(NUM_BITS'({f1_ff.lx, 4'b0000})) - $signed(NUM_BITS'(cfg.principal_x));
      f2_in.ny = $signed(NUM_BITS'({f1_ff.ly, 4'b0000})) - $signed(NUM_BITS'(cfg.principal_y));
      f2_in.nz = $signed(NUM_BITS'(cfg.focal_length));
   end

   always_comb begin
      f3_in.aw    = f2_ff.w[W_BITS-1] ? AW_BITS'(-f2_ff.w) : AW_BITS'(f2_ff.w);
      f3_in.wzero = (f2_ff.w == '0);
      nsel = '0;
      for (int i = 0; i < 3; i++) begin
         unique case (i)
            0:       nsel = f2_ff.nx;
            1:       nsel = f2_ff.ny;
            default: nsel = f2_ff.nz;
         endcase
         f3_in.an[i]  = nsel[NUM_BITS-1] ? AN_BITS'(-nsel) : AN_BITS'(nsel);
         f3_in.neg[i] = nsel[NUM_BITS-1] ^ f2_ff.w[W_BITS-1];
      end
   end

   always_comb begin
      f4_in.wzero = f3_ff.wzero;
      f4_in.dvs   = {f3_ff.aw, 1'b0};
      numer = '0;
      for (int i = 0; i < 3; i++) begin
         numer = (N_BITS'(f3_ff.an[i]) << 29) + N_BITS'(f3_ff.aw);
         f4_in.lane[i].rem = D_BITS'(numer[N_BITS-1:Q_BITS]);
         f4_in.lane[i].low = numer[Q_BITS-1:0];
         f4_in.lane[i].neg = f3_ff.neg[i];
         f4_in.lane[i].ovf = D_BITS'(numer[N_BITS-1:Q_BITS]) >= f4_in.dvs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ce) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         f1_ff <= f1_in;
         f2_ff <= f2_in;
         f3_ff <= f3_in;
         f4_ff <= f4_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_data  = f4_ff;

endmodule

/* hw/rtl/sdr_div_pipe.sv */
// Three restoring dividers in lockstep, one quotient bit per stage.
module sdr_div_pipe import sdr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          ce,
   input  logic          in_valid,
   input  div_stage_type in_data,
   output logic          out_valid,
   output div_stage_type out_data
);

   function automatic div_stage_type div_step(div_stage_type s);
      div_stage_type r;
      logic [D_BITS:0] t;
      logic            ge;
      r = s;
      for (int i = 0; i < 3; i++) begin
         t  = {s.lane[i].rem, s.lane[i].low[Q_BITS-1]};
         ge = (t >= {1'b0, s.dvs});
         r.lane[i].rem = ge ? D_BITS'(t - {1'b0, s.dvs}) : D_BITS'(t);
         r.lane[i].low = {s.lane[i].low[Q_BITS-2:0], ge};
      end
      return r;
   endfunction

   logic [Q_BITS-1:0] valid_ff;
   div_stage_type     stage_ff [Q_BITS];
   div_stage_type     stage_in [Q_BITS];

   always_comb begin
      stage_in[0] = div_step(in_data);
      for (int i = 1; i < Q_BITS; i++) begin
         stage_in[i] = div_step(stage_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ce) begin
         valid_ff <= {valid_ff[Q_BITS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < Q_BITS; i++) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   assign out_valid = valid_ff[Q_BITS-1];
   assign out_data  = stage_ff[Q_BITS-1];

endmodule

/* hw/rtl/sdr_range_pipe.sv */
// Quotient saturation, squares, digit-by-digit square root and result assembly.
module sdr_range_pipe import sdr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          ce,
   input  logic          in_valid,
   input  div_stage_type in_data,
   output logic          out_valid,
   output rsp_type       out_data
);

   function automatic logic [32:0] fin_coord(div_lane_type l);
      logic        sat;
      logic [31:0] val;
      if (l.neg) begin
         sat = l.ovf || (l.low > 32'h8000_0000);
         val = sat ? 32'h8000_0000 : 32'(-l.low);
      end else begin
         sat = l.ovf || l.low[31];
         val = sat ? 32'h7FFF_FFFF : l.low;
      end
      return {sat, val};
   endfunction

   function automatic sq_stage_type sq_step(sq_stage_type s);
      sq_stage_type          r;
      logic [SREM_BITS+1:0]  r4;
      logic [SREM_BITS+1:0]  trial;
      logic                  ge;
      r     = s;
      r4    = {s.rem, s.rad[RAD_BITS-1 -: 2]};
      trial = (SREM_BITS+2)'({s.root, 2'b01});
      ge    = (r4 >= trial);
      r.rem  = ge ? SREM_BITS'(r4 - trial) : SREM_BITS'(r4);
      r.root = {s.root[ROOT_BITS-2:0], ge};
      r.rad  = {s.rad[RAD_BITS-3:0], 2'b00};
      return r;
   endfunction

   typedef struct packed {
      coord_type          c;
      logic [RAD_BITS-1:0] sqx;
      logic [RAD_BITS-1:0] sqy;
      logic [RAD_BITS-1:0] sqz;
   } sq_sum_type;

   logic [2:0]         head_valid_ff;
   logic [ROOT_BITS:0] step_valid_ff;
   coord_type          e_ff, e_in;
   sq_sum_type         f_ff, f_in;
   sq_stage_type       g_ff, g_in;
   sq_stage_type       step_ff [ROOT_BITS];
   sq_stage_type       step_in [ROOT_BITS];
   rsp_type            res_ff, res_in;

   logic [32:0]        fx, fy, fz;
   logic [31:0]        ax, ay, az;
   logic [32:0]        rdist;
   logic               dsat;
   sq_stage_type       last;

   always_comb begin
      fx = fin_coord(in_data.lane[0]);
      fy = fin_coord(in_data.lane[1]);
      fz = fin_coord(in_data.lane[2]);
      e_in.wx    = $signed(fx[31:0]);
      e_in.wy    = $signed(fy[31:0]);
      e_in.wz    = $signed(fz[31:0]);
      e_in.sat   = fx[32] | fy[32] | fz[32];
      e_in.wzero = in_data.wzero;
   end

   always_comb begin
      ax = e_ff.wx[31] ? 32'(-e_ff.wx) : 32'(e_ff.wx);
      ay = e_ff.wy[31] ? 32'(-e_ff.wy) : 32'(e_ff.wy);
      az = e_ff.wz[31] ? 32'(-e_ff.wz) : 32'(e_ff.wz);
      f_in.c   = e_ff;
      f_in.sqx = ax * ax;
      f_in.sqy = ay * ay;
      f_in.sqz = az * az;
   end

   always_comb begin
      g_in.c    = f_ff.c;
      g_in.rem  = '0;
      g_in.root = '0;
      g_in.rad  = f_ff.sqx + f_ff.sqy + f_ff.sqz;
   end

   always_comb begin
      step_in[0] = sq_step(g_ff);
      for (int i = 1; i < ROOT_BITS; i++) begin
         step_in[i] = sq_step(step_ff[i-1]);
      end
   end

   always_comb begin
      last = step_ff[ROOT_BITS-1];
      rdist = 33'(last.root) + 33'(last.rem > SREM_BITS'(last.root));
      dsat = (rdist > 33'h0_7FFF_FFFF);
      if (last.c.wzero) begin
         res_in.world_x    = '0;
         res_in.world_y    = '0;
         res_in.world_z    = '0;
         res_in.range_dist = '0;
         res_in.status     = STATUS_WZERO;
      end else begin
         res_in.world_x    = last.c.wx;
         res_in.world_y    = last.c.wy;
         res_in.world_z    = last.c.wz;
         res_in.range_dist = dsat ? 31'h7FFF_FFFF : rdist[30:0];
         res_in.status     = (last.c.sat || dsat) ? STATUS_SAT : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= '0;
         step_valid_ff <= '0;
      end else if (ce) begin
         head_valid_ff <= {head_valid_ff[1:0], in_valid};
         step_valid_ff <= {step_valid_ff[ROOT_BITS-1:0], head_valid_ff[2]};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         e_ff   <= e_in;
         f_ff   <= f_in;
         g_ff   <= g_in;
         res_ff <= res_in;
         for (int i = 0; i < ROOT_BITS; i++) begin
            step_ff[i] <= step_in[i];
         end
      end
   end

   assign out_valid = step_valid_ff[ROOT_BITS];
   assign out_data  = res_ff;

endmodule

/* hw/rtl/sdr_out_buf.sv */
// Two-entry output buffer; its fill level gates the pipeline enable.
module sdr_out_buf import sdr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  rsp_type push_data,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   output logic    ce
);

   logic [1:0] fill_ff, fill_in;
   rsp_type    head_ff, head_in;
   rsp_type    tail_ff, tail_in;
   logic       push, pop;

   assign ce        = (fill_ff != 2'd2);
   assign push      = ce && push_valid;
   assign rsp_valid = (fill_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = head_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff + 2'(push) - 2'(pop);
      if (pop) begin
         if (fill_ff == 2'd2) begin
            head_in = tail_ff;
         end else if (push) begin
            head_in = push_data;
         end
      end else if (push) begin
         if (fill_ff == 2'd0) begin
            head_in = push_data;
         end else begin
            tail_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

/* hw/rtl/stereo_disparity_reprojection_unit.sv */
// Top level of the stereo disparity reprojection unit: registers and pipeline.
//
//  channel  ports                        direction  handshake
//  req      req_valid req_stall req_data in         valid / stall
//  rsp      rsp_valid rsp_stall rsp_data out        valid / stall
//  csr      csr_valid csr_ready csr_index csr_wdata in  valid / ready
//
// One transaction per cycle while the pipeline is not held; the path to rsp_valid
// runs through the 32-stage divider chain and the 32-stage square root chain.
// Synchronous active-high reset clears valid bits and sets the register file (w_offset to 16777216, rest zero).
// The whole pipeline holds while the two-entry output buffer is full; a
// stalled result never blocks acceptance until that buffer fills.
module stereo_disparity_reprojection_unit import sdr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   logic          ce;
   logic          front_valid, div_valid, range_valid;
   div_stage_type front_data, div_data;
   rsp_type       range_data;

   assign csr_ready = 1'b1;
   assign req_stall = !ce;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PRINCIPAL_X:    cfg_in.principal_x    = csr_wdata[15:0];
            CSR_PRINCIPAL_Y:    cfg_in.principal_y    = csr_wdata[15:0];
            CSR_FOCAL_LENGTH:   cfg_in.focal_length   = csr_wdata[19:0];
            CSR_DISPARITY_GAIN: cfg_in.disparity_gain = $signed(csr_wdata);
            CSR_W_OFFSET:       cfg_in.w_offset       = $signed(csr_wdata);
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.principal_x    <= '0;
         cfg_ff.principal_y    <= '0;
         cfg_ff.focal_length   <= '0;
         cfg_ff.disparity_gain <= '0;
         cfg_ff.w_offset       <= 32'sd16777216;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sdr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   sdr_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   sdr_range_pipe u_range (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .out_valid (range_valid),
      .out_data  (range_data)
   );

   sdr_out_buf u_obuf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (range_valid),
      .push_data  (range_data),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .ce         (ce)
   );

   a_wzero_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_WZERO |->
         rsp_data.world_x == '0 && rsp_data.world_y == '0 &&
         rsp_data.world_z == '0 && rsp_data.range_dist == '0)
      else $error("W-zero result carries nonzero fields");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status == STATUS_OK || rsp_data.status == STATUS_WZERO ||
                    rsp_data.status == STATUS_SAT)
      else $error("undefined status code");

   a_range_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_OK && rsp_data.world_x != '0 |->
         rsp_data.range_dist != '0)
      else $error("zero range with nonzero X");

   a_buf_full_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output buffer");

endmodule
